/* design/plfsr_pkg.sv */
package plfsr_pkg;

	// field widths
	localparam int unsigned SAMPLE_W = 10;
	localparam int unsigned SPEED_W  = 8;
	localparam int unsigned GAIN_W   = 24;
	localparam int unsigned PERIOD_W = 10;
	localparam int unsigned STEP_W   = 7;
	localparam int unsigned ERR_W    = 11;
	localparam int unsigned DIFF_W   = 12;
	localparam int unsigned SUM_W    = 32;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 24;

	// products and accumulator
	localparam int unsigned PROD_P_W = GAIN_W + 1 + ERR_W;
	localparam int unsigned PROD_I_W = GAIN_W + 1 + SUM_W;
	localparam int unsigned PROD_D_W = GAIN_W + 1 + DIFF_W;
	localparam int unsigned ACC_W    = PROD_I_W + 1;
	localparam int unsigned FRAC_W   = 16;

	localparam int TURN_LIMIT = 100;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRAY_LEVEL  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_PERIOD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP   = 3'd5;

	// reset values
	localparam logic [SAMPLE_W-1:0] GRAY_RST   = 10'd512;
	localparam logic [GAIN_W-1:0]   PROP_RST   = 24'd121242;
	localparam logic [GAIN_W-1:0]   INTEG_RST  = 24'd85;
	localparam logic [GAIN_W-1:0]   DERIV_RST  = 24'd393216;
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 10'd50;
	localparam logic [STEP_W-1:0]   STEP_RST   = 7'd2;

	typedef struct packed {
		logic [SAMPLE_W-1:0] gray_level;
		logic [GAIN_W-1:0]   prop_gain;
		logic [GAIN_W-1:0]   integ_gain;
		logic [GAIN_W-1:0]   deriv_gain;
		logic [PERIOD_W-1:0] ramp_period;
		logic [STEP_W-1:0]   ramp_step;
	} cfg_regs_t;

endpackage

/* design/pid_line_follow_with_speed_ramp_top.sv */
// Line-following PID steering with a ramped forward speed. Each accepted item
// (light sample, target speed, clear flag) yields one result: the forward
// command after this tick's ramp and the steering command, the negated PID sum
// in Q8.16 truncated toward zero and clamped to +/-100. One item can be taken
// every clock cycle while the output side does not stall; a result then moves
// through the stage 2, 3 and 4 registers and the result register. The rate is set
// by the update of the error sum, previous error and speed ramp, which every item
// reads from the one before it; the three gain multipliers and the final sum
// sit in later pipeline stages. Configuration writes are taken at any time
// (ready is always high) and must only be issued while the block is idle.
module pid_line_follow_with_speed_ramp_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [plfsr_pkg::SAMPLE_W-1:0]        light_sample,
	input  logic signed [plfsr_pkg::SPEED_W-1:0]  target_speed,
	input  logic                                  clear_history,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [plfsr_pkg::SPEED_W-1:0]  forward_cmd,
	output logic signed [plfsr_pkg::SPEED_W-1:0]  turn_cmd,
	// configuration write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [plfsr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [plfsr_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import plfsr_pkg::*;

	cfg_regs_t cfg_q;

	// pipeline control
	logic valid_s1, valid_s2, valid_s3, valid_s4, out_valid_q;
	logic ready_out, ready_s4, ready_s3, ready_s2, ready_s1;

	// stage 1: input register
	logic [SAMPLE_W-1:0]       sample_s1;
	logic signed [SPEED_W-1:0] target_s1;
	logic                      clear_s1;

	// controller state
	logic [PERIOD_W-1:0]       ramp_count_q;
	logic signed [SPEED_W-1:0] speed_q;
	logic signed [SUM_W-1:0]   error_sum_q;
	logic signed [ERR_W-1:0]   error_prev_q;

	// stage 2
	logic signed [ERR_W-1:0]   err_s2;
	logic signed [SUM_W-1:0]   sum_s2;
	logic signed [DIFF_W-1:0]  diff_s2;
	logic signed [SPEED_W-1:0] fwd_s2;

	// stage 3
	logic signed [PROD_P_W-1:0] prod_p_s3;
	logic signed [PROD_I_W-1:0] prod_i_s3;
	logic signed [PROD_D_W-1:0] prod_d_s3;
	logic signed [SPEED_W-1:0]  fwd_s3;

	// stage 4
	logic signed [ACC_W-1:0]   neg_s4;
	logic signed [SPEED_W-1:0] fwd_s4;

	// result register
	logic signed [SPEED_W-1:0] forward_q;
	logic signed [SPEED_W-1:0] turn_q;

	// combinational nets
	logic [PERIOD_W-1:0]       cnt_inc;
	logic                      do_ramp;
	logic signed [PERIOD_W-1:0] tgt_w, spd_w, stp_w, gap_w, up_w, dn_w, ramped_w;
	logic signed [SPEED_W-1:0] speed_next;
	logic [PERIOD_W-1:0]       count_next;
	logic                      polarity_pos;
	logic signed [ERR_W-1:0]   err_c;
	logic signed [SUM_W-1:0]   sum_base, sum_next;
	logic signed [ERR_W-1:0]   prev_base;
	logic signed [SUM_W:0]     sum_wide;
	logic signed [DIFF_W-1:0]  diff_c;
	logic signed [PROD_P_W-1:0] prod_p_c;
	logic signed [PROD_I_W-1:0] prod_i_c;
	logic signed [PROD_D_W-1:0] prod_d_c;
	logic signed [ACC_W-1:0]   neg_c, rnd_c;
	logic signed [ACC_W-FRAC_W-1:0] quo_c;
	logic signed [SPEED_W-1:0] turn_c;

	// handshake: each stage moves when its successor is empty or moving
	assign ready_out = !out_valid_q || !out_stall;
	assign ready_s4  = !valid_s4 || ready_out;
	assign ready_s3  = !valid_s3 || ready_s4;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign in_stall  = !ready_s1;
	assign out_valid = out_valid_q;
	assign forward_cmd = forward_q;
	assign turn_cmd    = turn_q;
	assign cfg_ready   = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gray_level  <= GRAY_RST;
			cfg_q.prop_gain   <= PROP_RST;
			cfg_q.integ_gain  <= INTEG_RST;
			cfg_q.deriv_gain  <= DERIV_RST;
			cfg_q.ramp_period <= PERIOD_RST;
			cfg_q.ramp_step   <= STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GRAY_LEVEL:  cfg_q.gray_level  <= cfg_data[SAMPLE_W-1:0];
				REG_PROP_GAIN:   cfg_q.prop_gain   <= cfg_data[GAIN_W-1:0];
				REG_INTEG_GAIN:  cfg_q.integ_gain  <= cfg_data[GAIN_W-1:0];
				REG_DERIV_GAIN:  cfg_q.deriv_gain  <= cfg_data[GAIN_W-1:0];
				REG_RAMP_PERIOD: cfg_q.ramp_period <= cfg_data[PERIOD_W-1:0];
				REG_RAMP_STEP:   cfg_q.ramp_step   <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready_s1)  valid_s1    <= in_valid;
			if (ready_s2)  valid_s2    <= valid_s1;
			if (ready_s3)  valid_s3    <= valid_s2;
			if (ready_s4)  valid_s4    <= valid_s3;
			if (ready_out) out_valid_q <= valid_s4;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			sample_s1 <= light_sample;
			target_s1 <= target_speed;
			clear_s1  <= clear_history;
		end
	end

	// speed ramp
	always_comb begin
		cnt_inc = ramp_count_q + PERIOD_W'(1);
		do_ramp = (cnt_inc >= cfg_q.ramp_period);
		tgt_w   = PERIOD_W'(target_s1);
		spd_w   = PERIOD_W'(speed_q);
		stp_w   = $signed({{(PERIOD_W-STEP_W){1'b0}}, cfg_q.ramp_step});
		gap_w   = tgt_w - spd_w;
		up_w    = spd_w + stp_w;
		dn_w    = spd_w - stp_w;
		if (!gap_w[PERIOD_W-1]) begin
			ramped_w = (up_w > tgt_w) ? tgt_w : up_w;
		end else begin
			ramped_w = (dn_w < tgt_w) ? tgt_w : dn_w;
		end
		speed_next = do_ramp ? ramped_w[SPEED_W-1:0] : speed_q;
		count_next = do_ramp ? '0 : cnt_inc;
	end

	// error, saturating sum and difference
	always_comb begin
		polarity_pos = !target_s1[SPEED_W-1] && (target_s1 != '0);
		if (polarity_pos) begin
			err_c = $signed({1'b0, cfg_q.gray_level}) - $signed({1'b0, sample_s1});
		end else begin
			err_c = $signed({1'b0, sample_s1}) - $signed({1'b0, cfg_q.gray_level});
		end
		sum_base  = clear_s1 ? '0 : error_sum_q;
		prev_base = clear_s1 ? '0 : error_prev_q;
		sum_wide  = (SUM_W+1)'(sum_base) + (SUM_W+1)'(err_c);
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
			                           : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum_next = sum_wide[SUM_W-1:0];
		end
		diff_c = DIFF_W'(err_c) - DIFF_W'(prev_base);
	end

	// controller state, updated as each item leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_count_q <= '0;
			speed_q      <= '0;
			error_sum_q  <= '0;
			error_prev_q <= '0;
		end else if (valid_s1 && ready_s2) begin
			ramp_count_q <= count_next;
			speed_q      <= speed_next;
			error_sum_q  <= sum_next;
			error_prev_q <= err_c;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			err_s2  <= err_c;
			sum_s2  <= sum_next;
			diff_s2 <= diff_c;
			fwd_s2  <= speed_next;
		end
	end

	// gain multipliers
	always_comb begin
		prod_p_c = $signed({1'b0, cfg_q.prop_gain}) * err_s2;
		prod_i_c = $signed({1'b0, cfg_q.integ_gain}) * sum_s2;
		prod_d_c = $signed({1'b0, cfg_q.deriv_gain}) * diff_s2;
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s3) begin
			prod_p_s3 <= prod_p_c;
			prod_i_s3 <= prod_i_c;
			prod_d_s3 <= prod_d_c;
			fwd_s3    <= fwd_s2;
		end
	end

	// negated PID sum
	assign neg_c = ACC_W'(0) - ACC_W'(prod_p_s3) - ACC_W'(prod_i_s3) - ACC_W'(prod_d_s3);

	always_ff @(posedge clk) begin
		if (valid_s3 && ready_s4) begin
			neg_s4 <= neg_c;
			fwd_s4 <= fwd_s3;
		end
	end

	// truncate toward zero, then clamp
	always_comb begin
		rnd_c = neg_s4 + (neg_s4[ACC_W-1] ? ACC_W'((1 << FRAC_W) - 1) : ACC_W'(0));
		quo_c = rnd_c[ACC_W-1:FRAC_W];
		if (quo_c > (ACC_W-FRAC_W)'(TURN_LIMIT)) begin
			turn_c = SPEED_W'(TURN_LIMIT);
		end else if (quo_c < -(ACC_W-FRAC_W)'(TURN_LIMIT)) begin
			turn_c = -SPEED_W'(TURN_LIMIT);
		end else begin
			turn_c = quo_c[SPEED_W-1:0];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (valid_s4 && ready_out) begin
			forward_q <= fwd_s4;
			turn_q    <= turn_c;
		end
	end

	// state only moves when an item leaves stage 1
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && ready_s2) |=> ($stable(speed_q) && $stable(error_sum_q)
			&& $stable(ramp_count_q)))
		else $error("controller state changed without an item transfer");

	// clearing restarts the sum from this item's error
	a_clear_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && ready_s2 && clear_s1) |=> (error_sum_q == SUM_W'(err_s2)))
		else $error("error sum not restarted on clear");

	// steering result stays within its limit
	a_turn_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (turn_q <= SPEED_W'(TURN_LIMIT) && turn_q >= -SPEED_W'(TURN_LIMIT)))
		else $error("turn command outside limit");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import plfsr_pkg::*;

	// indexes that select no register; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	typedef struct {
		logic signed [SPEED_W-1:0] forward;
		logic signed [SPEED_W-1:0] turn;
	} drive_cmd_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [SAMPLE_W-1:0]         light_sample = '0;
	logic signed [SPEED_W-1:0]   target_speed = '0;
	logic                        clear_history = 1'b0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic signed [SPEED_W-1:0]   forward_cmd;
	logic signed [SPEED_W-1:0]   turn_cmd;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index = '0;
	logic [CFG_DATA_W-1:0]       cfg_data = '0;

	// controller model state and register copy
	cfg_regs_t             ctrl_regs;
	logic [PERIOD_W-1:0]   ramp_ticks;
	int                    speed_now;
	int                    err_sum;
	int                    err_last;

	drive_cmd_t pending_cmds[$];

	int  mismatches = 0;
	int  ticks_sent = 0;
	int  cmds_checked = 0;
	int  reg_writes = 0;
	int  settings_used = 0;
	bit  steady_flow = 1'b0;
	int  hold_requests = 0;
	int  hold_served = 0;
	int  hold_left = 0;

	pid_line_follow_with_speed_ramp_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.light_sample  (light_sample),
		.target_speed  (target_speed),
		.clear_history (clear_history),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.forward_cmd   (forward_cmd),
		.turn_cmd      (turn_cmd),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// register write into the model copy
	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_GRAY_LEVEL:  ctrl_regs.gray_level  = data[SAMPLE_W-1:0];
			REG_PROP_GAIN:   ctrl_regs.prop_gain   = data[GAIN_W-1:0];
			REG_INTEG_GAIN:  ctrl_regs.integ_gain  = data[GAIN_W-1:0];
			REG_DERIV_GAIN:  ctrl_regs.deriv_gain  = data[GAIN_W-1:0];
			REG_RAMP_PERIOD: ctrl_regs.ramp_period = data[PERIOD_W-1:0];
			REG_RAMP_STEP:   ctrl_regs.ramp_step   = data[STEP_W-1:0];
			default: ;
		endcase
	endfunction

	// one control tick: speed ramp, then error history and PID steering
	function automatic void predict_tick(input logic [SAMPLE_W-1:0] sample,
		input logic signed [SPEED_W-1:0] target, input logic clr,
		output logic signed [SPEED_W-1:0] fwd, output logic signed [SPEED_W-1:0] turn);
		int     tgt, err, diff;
		longint total, acc;
		tgt = target;
		ramp_ticks = ramp_ticks + 1'b1;
		if (ramp_ticks >= ctrl_regs.ramp_period) begin
			if (tgt - speed_now >= 0) begin
				speed_now = speed_now + int'(ctrl_regs.ramp_step);
				if (speed_now > tgt) speed_now = tgt;
			end else begin
				speed_now = speed_now - int'(ctrl_regs.ramp_step);
				if (speed_now < tgt) speed_now = tgt;
			end
			ramp_ticks = '0;
		end
		if (clr) begin
			err_sum = 0;
			err_last = 0;
		end
		// error polarity follows the sign of the target speed
		if (tgt > 0) err = int'(ctrl_regs.gray_level) - int'(sample);
		else err = int'(sample) - int'(ctrl_regs.gray_level);
		total = longint'(err_sum) + longint'(err);
		if (total > 64'sd2147483647) total = 64'sd2147483647;
		if (total < -64'sd2147483648) total = -64'sd2147483648;
		err_sum = int'(total);
		diff = err - err_last;
		err_last = err;
		acc = longint'(ctrl_regs.prop_gain) * longint'(err)
			+ longint'(ctrl_regs.integ_gain) * longint'(err_sum)
			+ longint'(ctrl_regs.deriv_gain) * longint'(diff);
		acc = -acc / 65536;
		if (acc > TURN_LIMIT) acc = TURN_LIMIT;
		if (acc < -TURN_LIMIT) acc = -TURN_LIMIT;
		fwd = speed_now[SPEED_W-1:0];
		turn = acc[SPEED_W-1:0];
	endfunction

	function automatic void note_fail(input string msg);
		mismatches++;
		if (mismatches <= 10) $display("%s", msg);
	endfunction

	// offer one tick and hold it until the block takes it
	task automatic offer_tick(input logic [SAMPLE_W-1:0] sample,
		input logic signed [SPEED_W-1:0] target, input logic clr);
		logic signed [SPEED_W-1:0] fwd, turn;
		@(negedge clk);
		while (!steady_flow && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		light_sample  <= sample;
		target_speed  <= target;
		clear_history <= clr;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_tick(sample, target, clr, fwd, turn);
		pending_cmds.push_back('{fwd, turn});
		ticks_sent++;
	endtask

	// stop offering and wait until every command has come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_reg(idx, data);
		reg_writes++;
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_config(input cfg_regs_t c);
		drain();
		write_reg(REG_GRAY_LEVEL, CFG_DATA_W'(c.gray_level));
		write_reg(REG_PROP_GAIN, c.prop_gain);
		write_reg(REG_INTEG_GAIN, c.integ_gain);
		write_reg(REG_DERIV_GAIN, c.deriv_gain);
		write_reg(REG_RAMP_PERIOD, CFG_DATA_W'(c.ramp_period));
		write_reg(REG_RAMP_STEP, CFG_DATA_W'(c.ramp_step));
		end_writes();
		settings_used++;
	endtask

	// samples mostly near the line edge so the steering is not always clamped
	function automatic logic [SAMPLE_W-1:0] rand_sample();
		int g;
		if ($urandom_range(99) < 70) begin
			g = int'(ctrl_regs.gray_level) + int'($urandom_range(160)) - 80;
			if (g < 0) g = 0;
			if (g > 1023) g = 1023;
			return g[SAMPLE_W-1:0];
		end
		return SAMPLE_W'($urandom_range(1023));
	endfunction

	function automatic logic signed [SPEED_W-1:0] rand_target();
		int t;
		if ($urandom_range(99) < 80) t = int'($urandom_range(200)) - 100;
		else t = int'($urandom_range(255)) - 128;
		return t[SPEED_W-1:0];
	endfunction

	function automatic cfg_regs_t rand_config();
		cfg_regs_t c;
		c.gray_level = SAMPLE_W'($urandom_range(1023));
		case ($urandom_range(3))
			0: c.prop_gain = PROP_RST;
			1: c.prop_gain = GAIN_W'($urandom_range(262143));
			2: c.prop_gain = GAIN_W'($urandom_range(24'hFFFFFF));
			default: c.prop_gain = GAIN_W'($urandom_range(32767));
		endcase
		c.integ_gain = ($urandom_range(9) == 0) ? GAIN_W'($urandom_range(24'hFFFFFF))
			: GAIN_W'($urandom_range(4095));
		c.deriv_gain = ($urandom_range(3) == 0) ? GAIN_W'($urandom_range(24'hFFFFFF))
			: GAIN_W'($urandom_range(524287));
		c.ramp_period = ($urandom_range(7) == 0) ? PERIOD_W'($urandom_range(1023))
			: PERIOD_W'($urandom_range(8, 1));
		c.ramp_step = ($urandom_range(7) == 0) ? STEP_W'($urandom_range(127))
			: STEP_W'($urandom_range(6));
		return c;
	endfunction

	// extremes and alternating bit patterns of every field, reset settings
	task automatic test_field_extremes();
		offer_tick(10'd0, 8'sd127, 1'b1);
		offer_tick(10'd1023, -8'sd128, 1'b0);
		offer_tick(10'd512, 8'sd0, 1'b0);
		offer_tick(10'd511, 8'sd1, 1'b0);
		offer_tick(10'd513, -8'sd1, 1'b0);
		offer_tick(10'd1023, 8'sd100, 1'b0);
		offer_tick(10'd0, -8'sd100, 1'b0);
		offer_tick(10'd341, 8'sd85, 1'b1);
		offer_tick(10'd682, -8'sd86, 1'b0);
		offer_tick(10'd0, 8'sd1, 1'b0);
	endtask

	// zero period, largest step, no step, and a period cut short mid-count
	task automatic test_ramp_corners();
		load_config('{gray_level: 10'd1023, prop_gain: PROP_RST, integ_gain: INTEG_RST,
			deriv_gain: DERIV_RST, ramp_period: 10'd0, ramp_step: 7'd127});
		offer_tick(10'd0, 8'sd127, 1'b0);
		offer_tick(10'd1023, -8'sd128, 1'b0);
		offer_tick(10'd512, -8'sd128, 1'b1);
		offer_tick(10'd5, 8'sd100, 1'b0);
		load_config('{gray_level: GRAY_RST, prop_gain: PROP_RST, integ_gain: INTEG_RST,
			deriv_gain: DERIV_RST, ramp_period: 10'd1023, ramp_step: 7'd0});
		offer_tick(10'd700, 8'sd90, 1'b0);
		offer_tick(10'd300, -8'sd90, 1'b0);
		drain();
		write_reg(REG_SPARE_6, CFG_DATA_W'($urandom_range(24'hFFFFFF)));
		write_reg(REG_SPARE_7, CFG_DATA_W'($urandom_range(24'hFFFFFF)));
		write_reg(REG_RAMP_STEP, 24'd5);
		end_writes();
		offer_tick(10'd520, 8'sd50, 1'b0);
		// period dropped below the running count: update on the next tick
		drain();
		write_reg(REG_RAMP_PERIOD, 24'd2);
		end_writes();
		offer_tick(10'd480, 8'sd50, 1'b0);
		offer_tick(10'd530, 8'sd50, 1'b0);
	endtask

	// largest gains clamp both ways, zero gains give no steering
	task automatic test_gain_extremes();
		load_config('{gray_level: 10'd0, prop_gain: 24'hFFFFFF, integ_gain: 24'hFFFFFF,
			deriv_gain: 24'hFFFFFF, ramp_period: 10'd1, ramp_step: 7'd100});
		offer_tick(10'd1023, 8'sd1, 1'b0);
		offer_tick(10'd1023, -8'sd1, 1'b0);
		offer_tick(10'd0, -8'sd128, 1'b1);
		offer_tick(10'd1023, 8'sd127, 1'b0);
		load_config('{gray_level: 10'd1023, prop_gain: 24'd0, integ_gain: 24'd0,
			deriv_gain: 24'd0, ramp_period: 10'd1023, ramp_step: 7'd0});
		offer_tick(10'd1023, 8'sd50, 1'b0);
		offer_tick(10'd0, -8'sd50, 1'b1);
	endtask

	// receiver holds off for a long stretch while ticks keep coming
	task automatic test_backpressure();
		load_config('{gray_level: GRAY_RST, prop_gain: PROP_RST, integ_gain: INTEG_RST,
			deriv_gain: DERIV_RST, ramp_period: 10'd3, ramp_step: 7'd4});
		hold_requests++;
		steady_flow = 1'b1;
		for (int n = 0; n < 80; n++)
			offer_tick(rand_sample(), rand_target(), 1'($urandom_range(99) < 4));
		steady_flow = 1'b0;
	endtask

	// random ticks under a fresh random setting per phase
	task automatic test_random_phases();
		cfg_regs_t c;
		for (int ph = 0; ph < 10; ph++) begin
			c = rand_config();
			load_config(c);
			steady_flow = (ph == 3);
			if (ph == 6) hold_requests++;
			for (int n = 0; n < 127; n++)
				offer_tick(rand_sample(), rand_target(), 1'($urandom_range(99) < 4));
		end
		steady_flow = 1'b0;
	endtask

	// receiver side: random stalls, quiet stretches, long hold-offs
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = 250;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (steady_flow) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < 31);
		end
	end

	// compare each command transfer with the oldest prediction
	always @(posedge clk) begin : check_cmds
		drive_cmd_t want;
		if (arst_n && out_valid && !out_stall) begin
			cmds_checked++;
			if (pending_cmds.size() == 0) begin
				note_fail($sformatf("unexpected command: forward %0d turn %0d",
					forward_cmd, turn_cmd));
			end else begin
				want = pending_cmds.pop_front();
				if (forward_cmd !== want.forward)
					note_fail($sformatf("forward_cmd expected %0d got %0d",
						want.forward, forward_cmd));
				if (turn_cmd !== want.turn)
					note_fail($sformatf("turn_cmd expected %0d got %0d",
						want.turn, turn_cmd));
			end
		end
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		ctrl_regs = '{gray_level: GRAY_RST, prop_gain: PROP_RST, integ_gain: INTEG_RST,
			deriv_gain: DERIV_RST, ramp_period: PERIOD_RST, ramp_step: STEP_RST};
		ramp_ticks = '0;
		speed_now = 0;
		err_sum = 0;
		err_last = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_field_extremes();
		test_ramp_corners();
		test_gain_extremes();
		test_backpressure();
		test_random_phases();
		drain();

		$display("covered %0d ticks over %0d register settings (%0d writes),", ticks_sent,
			settings_used, reg_writes);
		$display("  %0d commands compared, %0d long hold-offs", cmds_checked, hold_served);
		if (mismatches == 0 && pending_cmds.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

/* files.f */
design/plfsr_pkg.sv
design/pid_line_follow_with_speed_ramp_top.sv
test/testbench.sv
